// ===== hdl/csnwm_pkg.sv =====
// ----------------------------------------------------------------------------
// csnwm_pkg
// Types and pattern tables for the charset name whitelist matcher.
// ----------------------------------------------------------------------------
package csnwm_pkg;

    typedef logic [7:0] t_byte;

    localparam int unsigned TABLE_SIZE = 8;
    localparam int unsigned PREFIX_MAX = 8;
    localparam int unsigned POS_W      = 5;
    localparam int unsigned IDX_W      = 3;

    typedef logic [POS_W-1:0]      t_pos;
    typedef logic [TABLE_SIZE-1:0] t_alive;
    typedef logic [IDX_W-1:0]      t_idx;

    localparam t_pos POS_MAX = t_pos'(31);

    // Prefix text, character 0 in the lowest byte.
    localparam t_byte PREFIX_TEXT [TABLE_SIZE][PREFIX_MAX] = '{
        '{"u", "s", "-", "a", "s", "c", "i", "i"},
        '{"i", "s", "o", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"u", "t", "f", "-", "7", 8'h00, 8'h00, 8'h00},
        '{"k", "o", "i", "8", "-", "r", 8'h00, 8'h00},
        '{"k", "o", "i", "8", "-", "u", 8'h00, 8'h00},
        '{"w", "i", "n", "d", "o", "w", "s", "-"},
        '{"c", "p", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"u", "t", "f", "-", "8", 8'h00, 8'h00, 8'h00}
    };

    localparam t_pos PREFIX_LEN [TABLE_SIZE] = '{
        t_pos'(8), t_pos'(3), t_pos'(5), t_pos'(6),
        t_pos'(6), t_pos'(8), t_pos'(2), t_pos'(5)
    };

    // Terminated patterns must end right after their prefix.
    localparam logic PREFIX_CLOSED [TABLE_SIZE] = '{
        1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0
    };

    localparam t_byte END_OF_NAME = 8'h00;

endpackage

// ===== hdl/charset_name_whitelist_matcher.sv =====
// ----------------------------------------------------------------------------
// charset_name_whitelist_matcher
// Checks a zero-terminated charset name, one byte per item, against a fixed
// table of eight name patterns and reports the first pattern that matched.
// ----------------------------------------------------------------------------
//
// Channel  | Dir | Fields (tdata, lowest bit first)
// ---------+-----+--------------------------------------------------------
// s (in)   | in  | char_code[7:0]
// m (out)  | out | whitelisted[0], match_index[3:1], zero pad [7:4]
//
// Flow: one byte is taken every clock unless a zero byte waits on a held
//   result. A byte is held in the input register, where all pattern checks
//   run in parallel against the running state; the zero byte then loads
//   the result register once the result slot is free.
// Reset: synchronous, active low; clears both valid flags, the byte position
//   and sets every pattern alive.
// Stalls: only a zero byte waits on the result register; other bytes never
//   stall, so input ready drops only while a result is held and a zero byte
//   waits behind it.
//
module charset_name_whitelist_matcher #(
    parameter int unsigned MAX_SUFFIX_CHARS = 8,
    parameter int unsigned PATTERN_COUNT    = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] char_code
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata    // [0] whitelisted, [3:1] match_index, [7:4] zero
);

    localparam int unsigned ACTIVE_COUNT =
        (PATTERN_COUNT > csnwm_pkg::TABLE_SIZE) ? csnwm_pkg::TABLE_SIZE : PATTERN_COUNT;
    localparam logic [5:0] SUFFIX_LIMIT = 6'(MAX_SUFFIX_CHARS);

    // Input register
    logic             r_in_valid;
    csnwm_pkg::t_byte r_in_data;

    // Matching state
    csnwm_pkg::t_pos   r_pos,   n_pos;
    csnwm_pkg::t_alive r_alive, n_alive;

    // Result register
    logic             r_out_valid, n_out_valid;
    logic             r_out_hit,   n_out_hit;
    csnwm_pkg::t_idx  r_out_idx,   n_out_idx;

    logic              out_free;
    logic              is_end;
    logic              in_go;
    csnwm_pkg::t_byte  folded;
    logic              suffix_char;
    csnwm_pkg::t_alive step_ok;
    logic              hit;
    csnwm_pkg::t_idx   hit_idx;

    // The result slot is free when empty or being taken this cycle.
    assign out_free   = !r_out_valid || i_m_tready;
    assign is_end     = (r_in_data == csnwm_pkg::END_OF_NAME);
    // Retire the held byte: plain bytes always, the end byte only into a free slot.
    assign in_go      = r_in_valid && (!is_end || out_free);
    assign o_s_tready = !r_in_valid || in_go;

    // Fold upper case to lower case; bytes above 0x7F stay as they are.
    always_comb begin
        if (r_in_data inside {["A":"Z"]}) begin
            folded = r_in_data + 8'h20;
        end else begin
            folded = r_in_data;
        end
        suffix_char = (r_in_data inside {["0":"9"]}) || (r_in_data == "-");
    end

    // Per-pattern check of the held byte against its position.
    always_comb begin
        csnwm_pkg::t_pos over;
        step_ok = '0;
        for (int p = 0; p < csnwm_pkg::TABLE_SIZE; p++) begin
            over = r_pos - csnwm_pkg::PREFIX_LEN[p];
            if (p >= ACTIVE_COUNT) begin
                step_ok[p] = 1'b0;
            end else if (r_pos < csnwm_pkg::PREFIX_LEN[p]) begin
                step_ok[p] = (folded == csnwm_pkg::PREFIX_TEXT[p][r_pos[2:0]]);
            end else if (csnwm_pkg::PREFIX_CLOSED[p]) begin
                step_ok[p] = 1'b0;
            end else begin
                step_ok[p] = suffix_char && ({1'b0, over} < SUFFIX_LIMIT);
            end
        end
    end

    // First live pattern whose prefix was fully seen.
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int p = csnwm_pkg::TABLE_SIZE - 1; p >= 0; p--) begin
            if ((p < ACTIVE_COUNT) && r_alive[p] && (r_pos >= csnwm_pkg::PREFIX_LEN[p])) begin
                hit     = 1'b1;
                hit_idx = csnwm_pkg::IDX_W'(p);
            end
        end
    end

    // Next state and result.
    always_comb begin
        n_pos       = r_pos;
        n_alive     = r_alive;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_hit   = r_out_hit;
        n_out_idx   = r_out_idx;
        if (in_go) begin
            if (is_end) begin
                n_pos       = '0;
                n_alive     = '1;
                n_out_valid = 1'b1;
                n_out_hit   = hit;
                n_out_idx   = hit_idx;
            end else begin
                n_alive = r_alive & step_ok;
                if (r_pos != csnwm_pkg::POS_MAX) begin
                    n_pos = r_pos + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_pos       <= '0;
            r_alive     <= '1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            r_pos       <= n_pos;
            r_alive     <= n_alive;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_data <= i_s_tdata;
        end
        r_out_hit <= n_out_hit;
        r_out_idx <= n_out_idx;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out_idx, r_out_hit};

`ifndef NO_ASSERTIONS
    // An end byte that retires must leave a result waiting.
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_go && is_end) |=> o_m_tvalid)
        else $error("end byte retired without a result");

    // After an end byte the matching state is back at its reset values.
    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_go && is_end) |=> (r_pos == '0) && (r_alive == '1))
        else $error("state not cleared after end of name");

    // An end byte blocked by a held result stays in the input register.
    a_end_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && is_end && r_out_valid && !i_m_tready)
            |=> r_in_valid && $stable(r_in_data))
        else $error("end byte lost while result stalled");

    // No match always reports index zero.
    a_miss_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[0]) |-> (o_m_tdata[3:1] == 3'd0))
        else $error("nonzero index without a match");
`endif

endmodule
